@@ design/ipv4_header_fragmenter_unit_assert.svh @@
// Assertion macros for the IPv4 header fragmenter.
`ifndef IPV4_HEADER_FRAGMENTER_UNIT_ASSERT_SVH
`define IPV4_HEADER_FRAGMENTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IHF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihf assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define IHF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihf assertion failed: next-cycle implication");

`endif

@@ design/ihf_pkg.sv @@
// Shared types, constants and helpers for the IPv4 header fragmenter.
package ihf_pkg;

    localparam int MAX_FRAGMENTS_DEF = 64;
    localparam int CFG_IDX_W         = 8;
    localparam int CFG_DATA_W        = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_MAX = 8'd1;

    localparam logic [10:0] FRAG_MAX_RESET = 11'd1400;
    localparam logic [15:0] HDR_BYTES      = 16'd20;
    localparam logic [10:0] UNIT_BYTES     = 11'd8;
    localparam int          UNIT_SHIFT     = 3;
    localparam logic [7:0]  VER_IHL        = 8'h45;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [10:0] frag_max;
    } cfg_t;

    typedef enum logic [2:0] {
        CS_NOP,
        CS_CLEAR,
        CS_ADD,
        CS_ADD_BASE,
        CS_ACCUM_BASE
    } csum_op_t;

    typedef struct packed {
        csum_op_t    op;
        logic [15:0] word;
    } csum_ctrl_t;

    // Chunk size in bytes: multiple of eight, never zero.
    function automatic logic [10:0] chunk_bytes(input logic [10:0] frag_max);
        logic [10:0] c;
        begin
            c = {frag_max[10:UNIT_SHIFT], {UNIT_SHIFT{1'b0}}};
            if (c == 11'd0)
            begin
                c = UNIT_BYTES;
            end
            return c;
        end
    endfunction

endpackage

@@ design/ihf_req_if.sv @@
// Request channel: one outgoing datagram.
interface ihf_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_length;
    logic [7:0]  protocol_number;
    logic [7:0]  service_type;
    logic [7:0]  hop_limit;
    logic [31:0] dest_address;

    modport source (output valid, payload_length, protocol_number, service_type,
                    hop_limit, dest_address, input ready);
    modport sink (input valid, payload_length, protocol_number, service_type,
                  hop_limit, dest_address, output ready);
endinterface

@@ design/ihf_res_if.sv @@
// Result channel: one fragment header.
interface ihf_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] packet_length;
    logic        more_fragments;
    logic [12:0] frag_offset;
    logic [15:0] identification;
    logic [15:0] header_checksum;
    logic        last;

    modport source (output valid, packet_length, more_fragments, frag_offset,
                    identification, header_checksum, last, input ready);
    modport sink (input valid, packet_length, more_fragments, frag_offset,
                  identification, header_checksum, last, output ready);
endinterface

@@ design/ihf_cfg_if.sv @@
// Configuration write channel.
interface ihf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ihf_pkg::CFG_IDX_W-1:0]    index;
    logic [ihf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/ipv4_header_fragmenter_unit.sv @@
// IPv4 fragment header generator: top level.
// One datagram request is taken when the block is idle; it then emits one header per
// fragment and returns to idle after the final one is taken. A request is accepted, the
// fixed header words are summed, and then for each fragment the block sizes it, finishes
// its checksum and offers the result, holding it while the result side stalls. The single
// 16-bit end-around-carry adder folds in one header word per cycle. Configuration writes
// are always accepted and must only be made while the block is idle.
module ipv4_header_fragmenter_unit #(
    parameter int MAX_FRAGMENTS = ihf_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ihf_req_if.sink    req,
    ihf_res_if.source  res,
    ihf_cfg_if.sink    cfg
);

    `include "ipv4_header_fragmenter_unit_assert.svh"

    ihf_pkg::cfg_t       cfg_regs;
    ihf_pkg::csum_ctrl_t csum_ctrl;
    logic [15:0]         csum_sum;

    ihf_cfg_regs u_cfg_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (cfg_regs)
    );

    ihf_csum_unit u_csum_unit (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (csum_ctrl),
        .sum  (csum_sum)
    );

    ihf_sequencer #(
        .MAX_FRAGMENTS(MAX_FRAGMENTS)
    ) u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .res      (res),
        .cfg      (cfg_regs),
        .csum_ctrl(csum_ctrl),
        .csum_sum (csum_sum)
    );

    `IHF_ASSERT_IMPL(a_busy_while_emitting, res.valid, !req.ready)
    `IHF_ASSERT_IMPL(a_last_excludes_mf, res.valid, res.last != res.more_fragments)
    `IHF_ASSERT_NEXT(a_idle_after_last, res.valid && res.ready && res.last, req.ready)
    `IHF_ASSERT_NEXT(a_request_starts_work, req.valid && req.ready, !req.ready && !res.valid)

endmodule

@@ design/ihf_cfg_regs.sv @@
// Configuration registers: source address and fragment size.
module ihf_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    ihf_cfg_if.sink        cfg,
    output ihf_pkg::cfg_t  regs
);

    logic [31:0] src_addr_reg;
    logic [10:0] frag_max_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_addr_reg <= 32'd0;
            frag_max_reg <= ihf_pkg::FRAG_MAX_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ihf_pkg::CFG_SRC_ADDR: src_addr_reg <= cfg.data;
                ihf_pkg::CFG_FRAG_MAX: frag_max_reg <= cfg.data[10:0];
                default: ;
            endcase
        end
    end

    assign regs.src_addr = src_addr_reg;
    assign regs.frag_max = frag_max_reg;

endmodule

@@ design/ihf_csum_unit.sv @@
// Shared one's-complement adder with running and base accumulators.
module ihf_csum_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  ihf_pkg::csum_ctrl_t ctrl,
    output logic [15:0]         sum
);

    logic [15:0] acc_reg;
    logic [15:0] base_reg;
    logic [15:0] opnd;
    logic [16:0] raw;
    logic [15:0] folded;

    // End-around carry add of one word.
    always_comb
    begin
        opnd   = (ctrl.op == ihf_pkg::CS_ADD_BASE) ? base_reg : acc_reg;
        raw    = {1'b0, opnd} + {1'b0, ctrl.word};
        folded = raw[15:0] + {15'd0, raw[16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 16'd0;
            base_reg <= 16'd0;
        end
        else
        begin
            case (ctrl.op)
                ihf_pkg::CS_CLEAR:
                begin
                    acc_reg  <= 16'd0;
                    base_reg <= 16'd0;
                end
                ihf_pkg::CS_ADD:      acc_reg <= folded;
                ihf_pkg::CS_ADD_BASE: acc_reg <= folded;
                ihf_pkg::CS_ACCUM_BASE:
                begin
                    acc_reg  <= folded;
                    base_reg <= folded;
                end
                default: ;
            endcase
        end
    end

    assign sum = acc_reg;

endmodule

@@ design/ihf_sequencer.sv @@
// Datagram sequencer: walks the fragments and drives the checksum unit.
module ihf_sequencer #(
    parameter int MAX_FRAGMENTS = ihf_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ihf_req_if.sink              req,
    ihf_res_if.source            res,
    input  ihf_pkg::cfg_t        cfg,
    output ihf_pkg::csum_ctrl_t  csum_ctrl,
    input  logic [15:0]          csum_sum
);

    localparam int CNT_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAGMENTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_FRAG_LEN,
        ST_FRAG_OFF,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        WS_TOS,
        WS_IDENT,
        WS_TTL_PROTO,
        WS_SRC_HI,
        WS_SRC_LO,
        WS_DST_HI,
        WS_DST_LO
    } word_sel_t;

    state_t      state_reg;
    word_sel_t   word_sel_reg;
    logic [15:0] ident_reg;
    logic [15:0] rem_reg;
    logic [12:0] off_reg;
    logic [CNT_W-1:0] count_reg;
    logic [10:0] chunk_reg;
    logic [10:0] take_reg;
    logic        final_reg;
    logic [7:0]  tos_reg;
    logic [7:0]  ttl_reg;
    logic [7:0]  proto_reg;
    logic [31:0] dst_reg;

    logic        out_valid_reg;
    logic [15:0] tot_out_reg;
    logic        mf_out_reg;
    logic [12:0] off_out_reg;
    logic [15:0] csum_out_reg;
    logic        last_out_reg;

    logic [15:0] take_c;
    logic [15:0] left_c;
    logic        final_c;
    logic [15:0] tot_c;
    logic [15:0] base_word;

    always_comb
    begin
        take_c  = (rem_reg > {5'd0, chunk_reg}) ? {5'd0, chunk_reg} : rem_reg;
        left_c  = rem_reg - take_c;
        final_c = (left_c == 16'd0) || (count_reg == CNT_LAST);
        tot_c   = take_c + ihf_pkg::HDR_BYTES;

        case (word_sel_reg)
            WS_TOS:       base_word = {ihf_pkg::VER_IHL, tos_reg};
            WS_IDENT:     base_word = ident_reg;
            WS_TTL_PROTO: base_word = {ttl_reg, proto_reg};
            WS_SRC_HI:    base_word = cfg.src_addr[31:16];
            WS_SRC_LO:    base_word = cfg.src_addr[15:0];
            WS_DST_HI:    base_word = dst_reg[31:16];
            WS_DST_LO:    base_word = dst_reg[15:0];
            default:      base_word = 16'd0;
        endcase

        csum_ctrl.op   = ihf_pkg::CS_NOP;
        csum_ctrl.word = 16'd0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    csum_ctrl.op = ihf_pkg::CS_CLEAR;
                end
            end
            ST_BASE:
            begin
                csum_ctrl.op   = ihf_pkg::CS_ACCUM_BASE;
                csum_ctrl.word = base_word;
            end
            ST_FRAG_LEN:
            begin
                // start each fragment from the fixed-word sum
                csum_ctrl.op   = ihf_pkg::CS_ADD_BASE;
                csum_ctrl.word = tot_c;
            end
            ST_FRAG_OFF:
            begin
                csum_ctrl.op   = ihf_pkg::CS_ADD;
                csum_ctrl.word = {2'b00, ~final_reg, off_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_sel_reg  <= WS_TOS;
            ident_reg     <= 16'd0;
            rem_reg       <= 16'd0;
            off_reg       <= 13'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        ident_reg    <= ident_reg + 16'd1;
                        rem_reg      <= req.payload_length;
                        off_reg      <= 13'd0;
                        count_reg    <= '0;
                        chunk_reg    <= ihf_pkg::chunk_bytes(cfg.frag_max);
                        tos_reg      <= req.service_type;
                        ttl_reg      <= req.hop_limit;
                        proto_reg    <= req.protocol_number;
                        dst_reg      <= req.dest_address;
                        word_sel_reg <= WS_TOS;
                        state_reg    <= ST_BASE;
                    end
                end
                ST_BASE:
                begin
                    if (word_sel_reg == WS_DST_LO)
                    begin
                        state_reg <= ST_FRAG_LEN;
                    end
                    else
                    begin
                        word_sel_reg <= word_sel_t'(word_sel_reg + 3'd1);
                    end
                end
                ST_FRAG_LEN:
                begin
                    take_reg    <= take_c[10:0];
                    final_reg   <= final_c;
                    rem_reg     <= left_c;
                    tot_out_reg <= tot_c;
                    state_reg   <= ST_FRAG_OFF;
                end
                ST_FRAG_OFF:
                begin
                    mf_out_reg   <= ~final_reg;
                    off_out_reg  <= off_reg;
                    last_out_reg <= final_reg;
                    state_reg    <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    csum_out_reg  <= ~csum_sum;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (res.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        off_reg       <= off_reg + {5'd0, take_reg[10:ihf_pkg::UNIT_SHIFT]};
                        count_reg     <= count_reg + CNT_W'(1);
                        // drop whatever payload remains after the final fragment
                        state_reg     <= final_reg ? ST_IDLE : ST_FRAG_LEN;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.packet_length   = tot_out_reg;
    assign res.more_fragments  = mf_out_reg;
    assign res.frag_offset     = off_out_reg;
    assign res.identification  = ident_reg;
    assign res.header_checksum = csum_out_reg;
    assign res.last            = last_out_reg;

endmodule

@@ tb/ipv4_header_fragmenter_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 fragment header generator: predicts and checks every header.
module ipv4_header_fragmenter_unit_tb;

    localparam int                            FRAG_LIMIT     = 64;
    localparam int                            MAX_IDLE       = 11;
    localparam int                            SETTLE_CYCLES  = 16;
    localparam logic [7:0]                    VERSION_IHL    = 8'h45;
    localparam int                            HEADER_LEN     = 20;
    localparam logic [10:0]                   FRAG_MAX_INIT  = 11'd1400;
    localparam logic [ihf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE  = 8'd2;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  protocol_number;
        logic [7:0]  service_type;
        logic [7:0]  hop_limit;
        logic [31:0] dest_address;
    } datagram_t;

    typedef struct packed {
        logic [15:0] packet_length;
        logic        more_fragments;
        logic [12:0] frag_offset;
        logic [15:0] identification;
        logic [15:0] header_checksum;
        logic        last;
    } frag_header_t;

    logic clk;
    logic rst_n;

    ihf_req_if req_ch ();
    ihf_res_if res_ch ();
    ihf_cfg_if cfg_ch ();

    ipv4_header_fragmenter_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Shadow of the block's registers and identification counter
    logic [31:0]  src_address_shadow;
    logic [10:0]  frag_max_shadow;
    logic [15:0]  datagram_id;

    frag_header_t pending_headers[$];
    int           mismatch_count;
    bit           sender_idle;
    bit           result_idle;
    int           result_stall;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous ceiling: several times the worst case of the traffic under the longest stalls
    initial
    begin
        #(10_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] fold_word(input logic [31:0] acc, input logic [15:0] word);
        logic [31:0] s;
        s = acc + {16'd0, word};
        return {16'd0, s[15:0]} + {16'd0, s[31:16]};
    endfunction

    function automatic logic [15:0] checksum_of(input datagram_t dg, input logic [15:0] tot,
                                                input logic mf, input logic [12:0] off);
        logic [15:0] words [9];
        logic [31:0] acc;
        words[0] = {VERSION_IHL, dg.service_type};
        words[1] = tot;
        words[2] = datagram_id;
        words[3] = {2'b00, mf, off};
        words[4] = {dg.hop_limit, dg.protocol_number};
        words[5] = src_address_shadow[31:16];
        words[6] = src_address_shadow[15:0];
        words[7] = dg.dest_address[31:16];
        words[8] = dg.dest_address[15:0];
        acc = 32'd0;
        foreach (words[i])
        begin
            acc = fold_word(acc, words[i]);
        end
        return ~acc[15:0];
    endfunction

    function automatic int chunk_size();
        int c;
        c = int'({frag_max_shadow[10:3], 3'b000});
        return (c == 0) ? 8 : c;
    endfunction

    // Split one request into fragments and queue the headers it must produce
    task automatic queue_fragment_headers(input datagram_t dg);
        int           chunk;
        int           remaining;
        int           take;
        int           offset_units;
        int           count;
        bit           is_final;
        frag_header_t h;
        chunk = chunk_size();
        datagram_id = datagram_id + 16'd1;
        remaining = int'(dg.payload_length);
        offset_units = 0;
        count = 0;
        is_final = 1'b0;
        while (!is_final)
        begin
            take = (remaining > chunk) ? chunk : remaining;
            remaining = remaining - take;
            // beyond the fragment limit the rest of the payload is dropped
            is_final = (remaining == 0) || (count + 1 >= FRAG_LIMIT);
            h.packet_length   = 16'(take + HEADER_LEN);
            h.more_fragments  = !is_final;
            h.frag_offset     = offset_units[12:0];
            h.identification  = datagram_id;
            h.header_checksum = checksum_of(dg, h.packet_length, h.more_fragments,
                                            h.frag_offset);
            h.last            = is_final;
            pending_headers.push_back(h);
            count++;
            offset_units = (offset_units + take / 8) & 13'h1FFF;
        end
    endtask

    task automatic send_datagram(input datagram_t dg);
        int gap;
        gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid           <= 1'b1;
        req_ch.payload_length  <= dg.payload_length;
        req_ch.protocol_number <= dg.protocol_number;
        req_ch.service_type    <= dg.service_type;
        req_ch.hop_limit       <= dg.hop_limit;
        req_ch.dest_address    <= dg.dest_address;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        queue_fragment_headers(dg);
    endtask

    task automatic hold_requests();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_headers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [ihf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
        hold_requests();
        wait_drained();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (idx == ihf_pkg::CFG_SRC_ADDR)
        begin
            src_address_shadow = value;
        end
        else if (idx == ihf_pkg::CFG_FRAG_MAX)
        begin
            frag_max_shadow = value[10:0];
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic datagram_t make_datagram(input int len);
        datagram_t dg;
        dg.payload_length  = 16'(len);
        dg.protocol_number = 8'($urandom);
        dg.service_type    = 8'($urandom);
        dg.hop_limit       = 8'($urandom);
        dg.dest_address    = $urandom;
        return dg;
    endfunction

    function automatic int random_payload();
        int chunk;
        int len;
        chunk = chunk_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = $urandom_range(0, 3 * chunk);
            // land on and around whole multiples of the chunk
            5, 6: len = $urandom_range(1, 8) * chunk + $urandom_range(0, 2) - 1;
            7, 8: len = $urandom_range(0, 16000);
            default: len = $urandom_range(0, 65515);
        endcase
        return (len > 65515) ? 65515 : len;
    endfunction

    function automatic void compare_field(input string field_name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, field_name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        frag_header_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            result_stall = result_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (pending_headers.size() == 0)
            begin
                $display("%0t unexpected header: expected none, got length %0d id 0x%0h",
                         $time, res_ch.packet_length, res_ch.identification);
                mismatch_count++;
            end
            else
            begin
                want = pending_headers.pop_front();
                compare_field("packet_length", 32'(want.packet_length),
                              32'(res_ch.packet_length));
                compare_field("more_fragments", 32'(want.more_fragments),
                              32'(res_ch.more_fragments));
                compare_field("frag_offset", 32'(want.frag_offset),
                              32'(res_ch.frag_offset));
                compare_field("identification", 32'(want.identification),
                              32'(res_ch.identification));
                compare_field("header_checksum", 32'(want.header_checksum),
                              32'(res_ch.header_checksum));
                compare_field("last", 32'(want.last), 32'(res_ch.last));
            end
        end
    end

    // Result side back-pressure: hold ready low for the drawn number of cycles
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (result_stall > 0)
            begin
                res_ch.ready <= 1'b0;
                result_stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_reset_settings();
        sender_idle = 1'b1;
        result_idle = 1'b1;
        send_datagram('{16'd0, 8'h00, 8'h00, 8'h00, 32'h0000_0000});
        send_datagram('{16'd1400, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
        send_datagram('{16'd1401, 8'h06, 8'hB8, 8'h40, 32'hC0A8_0101});
        send_datagram('{16'd65515, 8'h11, 8'h00, 8'hFF, 32'h0A00_0001});
    endtask

    task automatic test_source_address();
        write_register(ihf_pkg::CFG_SRC_ADDR, 32'hFFFF_FFFF);
        send_datagram('{16'd3000, 8'h01, 8'h10, 8'h80, 32'h7F00_0001});
        send_datagram('{16'd8, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF});
        write_register(ihf_pkg::CFG_SRC_ADDR, 32'hA5A5_5A5A);
        send_datagram('{16'd2801, 8'h5A, 8'hA5, 8'h01, 32'h5A5A_A5A5});
        // an unknown index must leave both registers alone
        write_register(CFG_IDX_SPARE, 32'h1234_5678);
        send_datagram('{16'd1500, 8'h2F, 8'h04, 8'h3C, 32'h0102_0304});
    endtask

    task automatic test_chunk_sizes();
        write_register(ihf_pkg::CFG_FRAG_MAX, 32'd1480);
        send_datagram(make_datagram(2960));
        write_register(ihf_pkg::CFG_FRAG_MAX, 32'd1024);
        send_datagram(make_datagram(1025));
        write_register(ihf_pkg::CFG_FRAG_MAX, 32'd2047);
        send_datagram(make_datagram(4096));
        // low three bits are ignored
        write_register(ihf_pkg::CFG_FRAG_MAX, 32'd1031);
        send_datagram(make_datagram(2048));
        write_register(ihf_pkg::CFG_FRAG_MAX, 32'd8);
        send_datagram(make_datagram(65515));
        // chunk rounds to zero, so eight bytes are used
        write_register(ihf_pkg::CFG_FRAG_MAX, 32'd7);
        send_datagram(make_datagram(100));
        write_register(ihf_pkg::CFG_FRAG_MAX, 32'd0);
        send_datagram(make_datagram(512));
        send_datagram(make_datagram(513));
        write_register(ihf_pkg::CFG_FRAG_MAX, 32'hFFFF_F5C8);
        send_datagram(make_datagram(3000));
    endtask

    task automatic test_random_traffic();
        logic [10:0] frag_choice [5];
        frag_choice[0] = 11'($urandom_range(1024, 1480));
        frag_choice[1] = 11'd1480;
        frag_choice[2] = 11'd1024;
        frag_choice[3] = 11'($urandom_range(0, 2047));
        frag_choice[4] = 11'($urandom_range(1024, 1480));
        for (int phase = 0; phase < 5; phase++)
        begin
            write_register(ihf_pkg::CFG_SRC_ADDR, $urandom);
            write_register(ihf_pkg::CFG_FRAG_MAX, {21'd0, frag_choice[phase]});
            for (int n = 0; n < 90; n++)
            begin
                if (n % 30 == 0)
                begin
                    sender_idle = ($urandom_range(0, 3) != 0);
                    result_idle = ($urandom_range(0, 3) != 0);
                end
                if (n == 45)
                begin
                    hold_requests();
                    wait_drained();
                end
                send_datagram(make_datagram(random_payload()));
            end
        end
    endtask

    task automatic test_back_to_back();
        write_register(ihf_pkg::CFG_FRAG_MAX, {21'd0, FRAG_MAX_INIT});
        sender_idle = 1'b0;
        result_idle = 1'b0;
        // single-fragment requests, as fast as the block takes them
        repeat (6)
        begin
            send_datagram(make_datagram($urandom_range(0, 1400)));
        end
        sender_idle = 1'b1;
        result_idle = 1'b1;
        repeat (4)
        begin
            send_datagram(make_datagram(random_payload()));
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.payload_length  = 16'd0;
        req_ch.protocol_number = 8'd0;
        req_ch.service_type    = 8'd0;
        req_ch.hop_limit       = 8'd0;
        req_ch.dest_address    = 32'd0;
        res_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = ihf_pkg::CFG_SRC_ADDR;
        cfg_ch.data            = 32'd0;
        src_address_shadow     = 32'd0;
        frag_max_shadow        = FRAG_MAX_INIT;
        datagram_id            = 16'd0;
        mismatch_count         = 0;
        result_stall           = 0;
        sender_idle            = 1'b1;
        result_idle            = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_source_address();
        test_chunk_sizes();
        test_random_traffic();
        test_back_to_back();

        hold_requests();
        wait_drained();
        mismatch_count += pending_headers.size();
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
